[rtl/bb3w_pkg.sv]
// package: shared types and constants for the wrapped 3x3 box blur
`default_nettype none
package bb3w_pkg;
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_RUN   = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_PASSES = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ_WAIT,
    ST_READ_DATA,
    ST_PIX_START,
    ST_TAP_ADDR,
    ST_TAP_LAST,
    ST_TAP_DRAIN,
    ST_PIX_WRITE,
    ST_COPY_ADDR,
    ST_COPY_WRITE,
    ST_RESULT
  } state_t;

  // rounded mean: floor((2*sum+9)/18) for sum up to 9*255
  function automatic logic [7:0] round_mean9(input logic [11:0] sum);
    logic [12:0] num;
    logic [25:0] prod;
    num  = {sum, 1'b0} + 13'd9;
    // 2^18/18 rounded up: exact for num < 4700
    prod = num * 15'd14564;
    return prod[25:18];
  endfunction
endpackage
`default_nettype wire

[rtl/bb3w_accum.sv]
// accumulator: sums nine rgb taps, one per cycle while add is high, and rounds the means
`default_nettype none
module bb3w_accum (
  input  wire logic        clk,
  input  wire logic        clear,
  input  wire logic        add,
  input  wire logic [23:0] tap,
  output logic      [23:0] mean
);
  logic [11:0] sum_b, sum_g, sum_r;

  always_ff @(posedge clk) begin
    if (clear) begin
      sum_b <= '0;
      sum_g <= '0;
      sum_r <= '0;
    end else if (add) begin
      sum_b <= sum_b + {4'd0, tap[7:0]};
      sum_g <= sum_g + {4'd0, tap[15:8]};
      sum_r <= sum_r + {4'd0, tap[23:16]};
    end
  end

  assign mean = {bb3w_pkg::round_mean9(sum_r), bb3w_pkg::round_mean9(sum_g),
                 bb3w_pkg::round_mean9(sum_b)};
endmodule
`default_nettype wire

[rtl/box_blur_3x3_wrap_unit.sv]
// top level: pixel store with an iterative wrapped 3x3 box smoothing sequencer
//
// requests come in on s_axis (tdata: pixel_row, pixel_col, in_blue, in_green,
// in_red from bit 0 up, tuser: req_type); one result leaves on m_axis per
// request (tdata: out_blue, out_green, out_red; tuser: out_error).
// the block takes one request at a time and is not ready until its result is
// taken. a write passes through read_wait to its result, a read through read_wait and read_data.
// a run request walks the frame: per pixel nine taps are read from the single
// read port of the current frame, one per cycle, then summed and written to
// the scratch frame, then the region is copied back; this repeats for pass_count
// passes.
// rst puts the sequencer in idle and the registers at width 256, height 256
// and 1000 passes; frame contents stay undefined until written.
// while the receiver stalls the result holds and no new request is taken.
// configuration writes (cfg_wr, cfg_index, cfg_data) are taken any cycle.
`default_nettype none
module box_blur_3x3_wrap_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // pixel_row, pixel_col, in_blue, in_green, in_red
  input  wire logic [1:0]  s_axis_tuser,  // req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [23:0] m_axis_tdata,  // out_blue, out_green, out_red
  output logic             m_axis_tuser,  // out_error
  input  wire logic        cfg_wr,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [9:0]  cfg_data
);
  localparam int CW = $clog2(MAX_WIDTH) > 0 ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = $clog2(MAX_HEIGHT) > 0 ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW = CW + RW;
  localparam int DEPTH = 2 ** AW;

  logic [8:0] image_width, image_height;
  logic [9:0] pass_count;
  logic [23:0] mem_cur [DEPTH];
  logic [23:0] mem_scr [DEPTH];

  bb3w_pkg::state_t state, state_next;
  logic [12:0] wd, hd;  // clamped sizes
  logic [7:0]  req_row, req_col;
  logic [1:0]  req_kind;
  logic [23:0] req_pix;
  logic [12:0] r, c, r_next, c_next;
  logic [1:0]  ta, tb, ta_next, tb_next;
  logic [9:0]  pass, pass_next;
  logic [23:0] out_data, out_data_next;
  logic        out_err, out_err_next;
  logic        in_image;
  logic [23:0] rd_cur, rd_scr;
  logic [AW-1:0] rd_addr, wr_addr;
  logic        we_cur, we_scr, acc_clear, acc_add;
  logic [23:0] mean, wr_data;
  logic [12:0] tr, tc;

  always_comb begin
    wd = (image_width == 9'd0) ? 13'd1 :
         ({4'd0, image_width} > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : {4'd0, image_width};
    hd = (image_height == 9'd0) ? 13'd1 :
         ({4'd0, image_height} > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : {4'd0, image_height};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd256;
      image_height <= 9'd256;
      pass_count   <= 10'd1000;
    end else if (cfg_wr) begin
      case (cfg_index)
        bb3w_pkg::CFG_WIDTH:  image_width  <= cfg_data[8:0];
        bb3w_pkg::CFG_HEIGHT: image_height <= cfg_data[8:0];
        bb3w_pkg::CFG_PASSES: pass_count   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_image = ({5'd0, req_row} < hd) && ({5'd0, req_col} < wd);

  // tap position with wrap around the active region
  always_comb begin
    if (ta == 2'd0) tr = (r == 13'd0) ? hd - 13'd1 : r - 13'd1;
    else if (ta == 2'd1) tr = r;
    else tr = (r + 13'd1 < hd) ? r + 13'd1 : 13'd0;
    if (tb == 2'd0) tc = (c == 13'd0) ? wd - 13'd1 : c - 13'd1;
    else if (tb == 2'd1) tc = c;
    else tc = (c + 13'd1 < wd) ? c + 13'd1 : 13'd0;
  end

  always_ff @(posedge clk) begin
    if (we_cur) mem_cur[wr_addr] <= wr_data;
    rd_cur <= mem_cur[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we_scr) mem_scr[wr_addr] <= mean;
    rd_scr <= mem_scr[rd_addr];
  end

  bb3w_accum u_accum (
    .clk(clk), .clear(acc_clear), .add(acc_add), .tap(rd_cur), .mean(mean)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bb3w_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
    r <= r_next; c <= c_next; ta <= ta_next; tb <= tb_next; pass <= pass_next;
    out_data <= out_data_next; out_err <= out_err_next;
    if (s_axis_tvalid && s_axis_tready) begin
      req_row  <= s_axis_tdata[7:0];
      req_col  <= s_axis_tdata[15:8];
      req_pix  <= s_axis_tdata[39:16];
      req_kind <= s_axis_tuser;
    end
  end

  always_comb begin
    state_next = state;
    r_next = r; c_next = c; ta_next = ta; tb_next = tb; pass_next = pass;
    out_data_next = out_data; out_err_next = out_err;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    we_cur = 1'b0; we_scr = 1'b0; acc_clear = 1'b0; acc_add = 1'b0;
    wr_data = req_pix;
    wr_addr = {RW'(req_row), CW'(req_col)};
    rd_addr = {RW'(req_row), CW'(req_col)};
    case (state)
      bb3w_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = bb3w_pkg::ST_READ_WAIT;
      end
      bb3w_pkg::ST_READ_WAIT: begin
        out_data_next = '0;
        out_err_next  = 1'b0;
        case (req_kind)
          bb3w_pkg::REQ_WRITE: begin
            out_err_next = !in_image;
            we_cur = in_image;
            state_next = bb3w_pkg::ST_RESULT;
          end
          bb3w_pkg::REQ_READ: begin
            out_err_next = !in_image;
            state_next = bb3w_pkg::ST_READ_DATA;
          end
          bb3w_pkg::REQ_RUN: begin
            pass_next = '0;
            r_next = '0; c_next = '0;
            state_next = (pass_count == 10'd0) ? bb3w_pkg::ST_RESULT
                                               : bb3w_pkg::ST_PIX_START;
          end
          default: state_next = bb3w_pkg::ST_RESULT;
        endcase
      end
      bb3w_pkg::ST_READ_DATA: begin
        out_data_next = in_image ? rd_cur : 24'd0;
        state_next = bb3w_pkg::ST_RESULT;
      end
      bb3w_pkg::ST_PIX_START: begin
        acc_clear = 1'b1;
        ta_next = 2'd0; tb_next = 2'd0;
        state_next = bb3w_pkg::ST_TAP_ADDR;
      end
      bb3w_pkg::ST_TAP_ADDR: begin
        // read issued now, summed in the next cycle
        rd_addr = {tr[RW-1:0], tc[CW-1:0]};
        if (!(ta == 2'd0 && tb == 2'd0)) acc_add = 1'b1;
        if (tb == 2'd2) begin
          tb_next = 2'd0;
          ta_next = ta + 2'd1;
          if (ta == 2'd2) state_next = bb3w_pkg::ST_TAP_DRAIN;
        end else begin
          tb_next = tb + 2'd1;
        end
      end
      bb3w_pkg::ST_TAP_DRAIN: begin
        acc_add = 1'b1;
        state_next = bb3w_pkg::ST_PIX_WRITE;
      end
      bb3w_pkg::ST_PIX_WRITE: begin
        we_scr = 1'b1;
        wr_addr = {r[RW-1:0], c[CW-1:0]};
        if (c + 13'd1 < wd) begin
          c_next = c + 13'd1;
          state_next = bb3w_pkg::ST_PIX_START;
        end else if (r + 13'd1 < hd) begin
          c_next = '0; r_next = r + 13'd1;
          state_next = bb3w_pkg::ST_PIX_START;
        end else begin
          c_next = '0; r_next = '0;
          state_next = bb3w_pkg::ST_COPY_ADDR;
        end
      end
      bb3w_pkg::ST_COPY_ADDR: begin
        rd_addr = {r[RW-1:0], c[CW-1:0]};
        state_next = bb3w_pkg::ST_COPY_WRITE;
      end
      bb3w_pkg::ST_COPY_WRITE: begin
        we_cur = 1'b1;
        wr_data = rd_scr;
        wr_addr = {r[RW-1:0], c[CW-1:0]};
        state_next = bb3w_pkg::ST_COPY_ADDR;
        if (c + 13'd1 < wd) begin
          c_next = c + 13'd1;
        end else if (r + 13'd1 < hd) begin
          c_next = '0; r_next = r + 13'd1;
        end else begin
          c_next = '0; r_next = '0;
          pass_next = pass + 10'd1;
          state_next = (pass + 10'd1 == pass_count) ? bb3w_pkg::ST_RESULT
                                                    : bb3w_pkg::ST_PIX_START;
        end
      end
      bb3w_pkg::ST_TAP_LAST: state_next = bb3w_pkg::ST_TAP_DRAIN;
      bb3w_pkg::ST_RESULT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) state_next = bb3w_pkg::ST_IDLE;
      end
      default: state_next = bb3w_pkg::ST_IDLE;
    endcase
  end

  assign m_axis_tdata = out_data;
  assign m_axis_tuser = out_err;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != bb3w_pkg::ST_IDLE) |-> !s_axis_tready)
    else $error("request taken while busy");
  a_result_after_req: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !m_axis_tvalid)
    else $error("result shown before request processed");
  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == 24'd0))
    else $error("error result carries pixel data");
`endif
endmodule
`default_nettype wire

[tb/tb.sv]
// testbench for the wrapped 3x3 box blur unit: directed table, then random phases
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [1:0] CFG_SPARE  = 2'd3;
  localparam int FRAME_DIM = 256;
  localparam int CYCLE_LIMIT = 10000000;
  localparam int N_DIRECTED = 20;
  localparam int CFG_ROW = 7;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       typed;
    logic [24:0] res;   // error, red, green, blue
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = bb3w_pkg::REQ_WRITE;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_wr = 1'b0;
  logic [1:0] cfg_index = bb3w_pkg::CFG_WIDTH;
  logic [9:0] cfg_data = '0;

  box_blur_3x3_wrap_unit DUT (.*);

  // shadow of the pixel store and the registers
  logic [23:0] frame_now [FRAME_DIM*FRAME_DIM];
  logic [23:0] frame_tmp [FRAME_DIM*FRAME_DIM];
  logic [9:0]  reg_width = 10'd256;
  logic [9:0]  reg_height = 10'd256;
  logic [9:0]  reg_passes = 10'd1000;

  logic [24:0] pixel_due [$];
  int fail_count = 0;
  int cycles = 0;
  bit quiet = 0;
  int stall_pct = 20;

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int active_w();
    int v;
    v = reg_width[8:0];
    return (v < 1) ? 1 : (v > FRAME_DIM) ? FRAME_DIM : v;
  endfunction

  function automatic int active_h();
    int v;
    v = reg_height[8:0];
    return (v < 1) ? 1 : (v > FRAME_DIM) ? FRAME_DIM : v;
  endfunction

  task automatic blur_pass(input int w, input int h);
    int up, dn, lf, rt, sb, sg, sr;
    int rr [3];
    int cc [3];
    logic [23:0] p;
    for (int r = 0; r < h; r++) begin
      up = (r > 0) ? r - 1 : h - 1;
      dn = (r + 1 < h) ? r + 1 : 0;
      rr[0] = up; rr[1] = r; rr[2] = dn;
      for (int c = 0; c < w; c++) begin
        lf = (c > 0) ? c - 1 : w - 1;
        rt = (c + 1 < w) ? c + 1 : 0;
        cc[0] = lf; cc[1] = c; cc[2] = rt;
        sb = 0; sg = 0; sr = 0;
        for (int a = 0; a < 3; a++)
          for (int b = 0; b < 3; b++) begin
            p = frame_now[rr[a]*FRAME_DIM + cc[b]];
            sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
          end
        // mean rounded half up
        frame_tmp[r*FRAME_DIM + c] = {8'((2*sr+9)/18), 8'((2*sg+9)/18), 8'((2*sb+9)/18)};
      end
    end
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++)
        frame_now[r*FRAME_DIM + c] = frame_tmp[r*FRAME_DIM + c];
  endtask

  task automatic predict_pixel(input stim_row_t s, output logic [24:0] res);
    int w, h, addr;
    bit in_img;
    w = active_w();
    h = active_h();
    in_img = (s.row < h) && (s.col < w);
    addr = s.row*FRAME_DIM + s.col;
    res = '0;
    case (s.kind)
      bb3w_pkg::REQ_WRITE: begin
        if (in_img) frame_now[addr] = {s.red, s.green, s.blue};
        else res[24] = 1'b1;
      end
      bb3w_pkg::REQ_RUN: for (int k = 0; k < reg_passes; k++) blur_pass(w, h);
      bb3w_pkg::REQ_READ: begin
        if (in_img) res[23:0] = frame_now[addr];
        else res[24] = 1'b1;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input stim_row_t s);
    logic [24:0] res;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= s.kind;
    s_axis_tdata <= {s.red, s.green, s.blue, s.col, s.row};
    do @(posedge clk); while (!s_axis_tready);
    predict_pixel(s, res);
    pixel_due.push_back(s.typed ? s.res : res);
    if (!quiet && $urandom_range(0, 99) < stall_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_and_wait();
    s_axis_tvalid <= 1'b0;
    while (pixel_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic program_regs(input logic [9:0] w, input logic [9:0] h, input logic [9:0] p);
    cfg_wr <= 1'b1; cfg_index <= bb3w_pkg::CFG_WIDTH; cfg_data <= w;
    @(posedge clk);
    cfg_index <= bb3w_pkg::CFG_HEIGHT; cfg_data <= h;
    @(posedge clk);
    cfg_index <= bb3w_pkg::CFG_PASSES; cfg_data <= p;
    @(posedge clk);
    // index past the register list must be ignored
    cfg_index <= CFG_SPARE; cfg_data <= 10'($urandom);
    @(posedge clk);
    cfg_wr <= 1'b0;
    @(posedge clk);
    reg_width = w; reg_height = h; reg_passes = p;
  endtask

  function automatic stim_row_t rand_row(input logic [1:0] kind, input int w, input int h);
    stim_row_t s;
    s.kind = kind;
    if ($urandom_range(0, 9) < 7) begin
      s.row = 8'($urandom_range(0, h - 1));
      s.col = 8'($urandom_range(0, w - 1));
    end else begin
      s.row = 8'($urandom);
      s.col = 8'($urandom);
    end
    s.blue = 8'($urandom); s.green = 8'($urandom); s.red = 8'($urandom);
    s.typed = 1'b0;
    s.res = '0;
    return s;
  endfunction

  always @(posedge clk) begin
    logic [24:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pixel_due.size() == 0) begin
        $error("result with no request pending: blue %0h green %0h red %0h error %0b",
               m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tuser);
        fail_count++;
      end else begin
        want = pixel_due.pop_front();
        if (m_axis_tdata[7:0] !== want[7:0]) begin
          $error("out_blue expected %0h got %0h", want[7:0], m_axis_tdata[7:0]);
          fail_count++;
        end
        if (m_axis_tdata[15:8] !== want[15:8]) begin
          $error("out_green expected %0h got %0h", want[15:8], m_axis_tdata[15:8]);
          fail_count++;
        end
        if (m_axis_tdata[23:16] !== want[23:16]) begin
          $error("out_red expected %0h got %0h", want[23:16], m_axis_tdata[23:16]);
          fail_count++;
        end
        if (m_axis_tuser !== want[24]) begin
          $error("out_error expected %0b got %0b", want[24], m_axis_tuser);
          fail_count++;
        end
      end
    end
  end

  // result side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  stim_row_t dir_tab [N_DIRECTED] = '{
    '{bb3w_pkg::REQ_WRITE, 8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_READ,  8'd255, 8'd255, 8'h00, 8'h00, 8'h00, 1'b1, 25'h0ffffff},
    '{bb3w_pkg::REQ_READ,  8'd0,   8'd0,   8'hff, 8'hff, 8'hff, 1'b1, 25'h0},
    '{REQ_UNUSED,          8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 1'b1, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd0,   8'd255, 8'h55, 8'haa, 8'h5a, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_READ,  8'd0,   8'd255, 8'h00, 8'h00, 8'h00, 1'b0, 25'h0},
    // from here the image is 3 wide and 2 high
    '{bb3w_pkg::REQ_WRITE, 8'd0,   8'd0,   8'hff, 8'h00, 8'h80, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd0,   8'd1,   8'h00, 8'hff, 8'h01, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd0,   8'd2,   8'hff, 8'hff, 8'hff, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd1,   8'd0,   8'h12, 8'h34, 8'h56, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd1,   8'd1,   8'h00, 8'h00, 8'h00, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd1,   8'd2,   8'h7f, 8'h80, 8'h81, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_WRITE, 8'd2,   8'd0,   8'h11, 8'h22, 8'h33, 1'b1, 25'h1000000},
    '{bb3w_pkg::REQ_READ,  8'd0,   8'd3,   8'h00, 8'h00, 8'h00, 1'b1, 25'h1000000},
    '{bb3w_pkg::REQ_READ,  8'd255, 8'd255, 8'h00, 8'h00, 8'h00, 1'b1, 25'h1000000},
    '{bb3w_pkg::REQ_RUN,   8'd255, 8'd255, 8'hff, 8'hff, 8'hff, 1'b1, 25'h0},
    '{bb3w_pkg::REQ_READ,  8'd1,   8'd1,   8'h00, 8'h00, 8'h00, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_READ,  8'd0,   8'd2,   8'h00, 8'h00, 8'h00, 1'b0, 25'h0},
    '{bb3w_pkg::REQ_RUN,   8'd0,   8'd0,   8'h00, 8'h00, 8'h00, 1'b1, 25'h0}
  };

  // width, height, passes per phase; clamped sizes and pass extremes included
  logic [9:0] phase_w [10] = '{10'd0,   10'd511, 10'd1,   10'd5, 10'd8,
                               10'd2,   10'd256, 10'd7,   10'd4, 10'd6};
  logic [9:0] phase_h [10] = '{10'd0,   10'd1,   10'd300, 10'd4, 10'd8,
                               10'd7,   10'd2,   10'd3,   10'd4, 10'd5};
  logic [9:0] phase_p [10] = '{10'd1023, 10'd2,  10'd1,   10'd0, 10'd3,
                               10'd2,   10'd1,   10'd5,   10'd1, 10'd1023};

  initial begin
    int w, h, pick;
    stim_row_t s;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (i == CFG_ROW) begin
        drain_and_wait();
        program_regs(10'd3, 10'd2, 10'd1);
      end
      send_request(dir_tab[i]);
    end

    for (int ph = 0; ph < 10; ph++) begin
      drain_and_wait();
      program_regs(phase_w[ph], phase_h[ph], phase_p[ph]);
      quiet = (ph == 9);
      stall_pct = (ph % 4 == 2) ? 0 : $urandom_range(10, 40);
      w = active_w();
      h = active_h();
      // fill the whole image so every later read and run sees written pixels
      for (int r = 0; r < h; r++)
        for (int c = 0; c < w; c++) begin
          s = rand_row(bb3w_pkg::REQ_WRITE, w, h);
          s.row = 8'(r);
          s.col = 8'(c);
          send_request(s);
        end
      for (int n = 0; n < 30; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) s = rand_row(bb3w_pkg::REQ_RUN, w, h);
        else if (pick < 12) s = rand_row(REQ_UNUSED, w, h);
        else if (pick < 52) s = rand_row(bb3w_pkg::REQ_WRITE, w, h);
        else s = rand_row(bb3w_pkg::REQ_READ, w, h);
        send_request(s);
      end
    end

    drain_and_wait();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
rtl/bb3w_pkg.sv
rtl/bb3w_accum.sv
rtl/box_blur_3x3_wrap_unit.sv
tb/tb.sv
